// ===== hdl/dare_pkg.sv =====
// ----------------------------------------------------------------------------
// DNS A-record extractor: shared definitions
// Phase codes, status codes, message layout constants and the structures
// passed between the transfer stage and the parser.
// ----------------------------------------------------------------------------
package dare_pkg;

   // Message layout
   localparam logic [3:0] HdrLastPos   = 4'd11;  // final header byte index
   localparam logic [3:0] AnCountHiPos = 4'd6;
   localparam logic [3:0] AnCountLoPos = 4'd7;
   localparam logic [3:0] TypeHiPos    = 4'd0;
   localparam logic [3:0] TypeLoPos    = 4'd1;
   localparam logic [3:0] RdLenHiPos   = 4'd8;
   localparam logic [3:0] RdLenLoPos   = 4'd9;   // final fixed-part byte index
   localparam logic [3:0] AddrLastPos  = 4'd3;   // final address byte index
   localparam logic [15:0] TypeA       = 16'd1;
   localparam logic [15:0] ALen        = 16'd4;
   localparam logic [7:0]  PtrMask     = 8'hC0;
   localparam logic [15:0] QTailLen    = 16'd4;  // type and class
   localparam logic [15:0] QTailPtrLen = 16'd5;  // pointer second byte + tail
   localparam logic [15:0] PtrTailLen  = 16'd1;  // pointer second byte

   // Status codes
   localparam logic [2:0] StFound = 3'd0;
   localparam logic [2:0] StShort = 3'd1;
   localparam logic [2:0] StNoAns = 3'd2;
   localparam logic [2:0] StTrunc = 3'd3;
   localparam logic [2:0] StNoA   = 3'd4;
   localparam logic [2:0] StNone  = 3'd7;

   // Parse phases, one-hot
   typedef enum logic [10:0] {
      PH_HDR    = 11'b000_0000_0001,
      PH_QNAME  = 11'b000_0000_0010,
      PH_QLABEL = 11'b000_0000_0100,
      PH_QTAIL  = 11'b000_0000_1000,
      PH_ANAME  = 11'b000_0001_0000,
      PH_ALABEL = 11'b000_0010_0000,
      PH_ASKIP  = 11'b000_0100_0000,
      PH_FIXED  = 11'b000_1000_0000,
      PH_RDATA  = 11'b001_0000_0000,
      PH_RSKIP  = 11'b010_0000_0000,
      PH_DONE   = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       last;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  status;
      logic [31:0] ipv4_address;
   } result_type;

endpackage

// ===== hdl/dns_a_record_extractor.sv =====
// ----------------------------------------------------------------------------
// DNS A-record extractor: top level
// Input register, byte parser and result register with handshakes.
// ----------------------------------------------------------------------------
// Accepts one DNS response byte per clock cycle on the req_ channel, with
// req_last marking the final byte of each message, and gives exactly one
// result per message on the rsp_ channel: a status code and, when the status
// is found, the IPv4 address of the first A record with a four-byte data
// field. Each byte passes through an input register before it is parsed,
// and the result of a message is held in a result register, loaded when
// its final byte is parsed. Throughput is one byte per cycle, limited
// only by the single result register: input stalls only when a final byte
// meets a result that the consumer has not yet taken.
module dns_a_record_extractor
   import dare_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_ipv4_address
);

   logic        in_valid_ff, in_valid_in;
   item_type    in_item_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff;
   logic [31:0] rsp_addr_ff;
   logic        req_fire;
   logic        step;
   result_type  result;

   // The parser takes the held byte unless it would produce a result that
   // has nowhere to go.
   assign step      = in_valid_ff && !(in_item_ff.last && rsp_valid_ff && !rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.msg_byte <= req_msg_byte;
         in_item_ff.last     <= req_last;
      end
   end

   dare_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .result (result)
   );

   // Result register: loaded by a finished message, emptied by a transfer.
   always_comb begin
      if (result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_status_ff <= result.status;
         rsp_addr_ff   <= result.ipv4_address;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_ipv4_address = rsp_addr_ff;

   // Only a found status carries an address.
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != StFound) |-> (rsp_ipv4_address == 32'd0))
      else $error("address given without a found status");

   // Status codes stay within the defined set.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == StFound || rsp_status == StShort ||
                     rsp_status == StNoAns || rsp_status == StTrunc ||
                     rsp_status == StNoA))
      else $error("undefined status code");

   // A new result only follows a parsed final byte.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step && in_item_ff.last))
      else $error("result appeared without a final byte");

endmodule

// ===== hdl/dare_parser.sv =====
// ----------------------------------------------------------------------------
// DNS A-record extractor: byte parser
// Holds the parse state and advances it by one message byte per step. On
// the final byte it forms the result and returns to its reset state.
// ----------------------------------------------------------------------------
module dare_parser
   import dare_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   output result_type result
);

   phase_type   phase_ff, phase_in, phase_nx;
   logic [3:0]  pos_ff, pos_in, pos_nx;
   logic [15:0] answers_ff, answers_in, answers_nx;
   logic [15:0] skip_ff, skip_in, skip_nx;
   logic [15:0] rtype_ff, rtype_in, rtype_nx;
   logic [15:0] rdlen_ff, rdlen_in, rdlen_nx;
   logic [31:0] addr_ff, addr_in, addr_nx;
   logic [2:0]  outcome_ff, outcome_in, outcome_nx;
   logic [7:0]  b;
   logic        is_ptr;
   logic [15:0] skip_dec;
   logic [15:0] answers_dec;
   logic [2:0]  status;

   assign b           = item.msg_byte;
   assign is_ptr      = (b & PtrMask) == PtrMask;
   assign skip_dec    = skip_ff - 16'd1;
   assign answers_dec = answers_ff - 16'd1;

   // Advance the parse state by one byte while no outcome is fixed.
   always_comb begin
      phase_nx   = phase_ff;
      pos_nx     = pos_ff;
      answers_nx = answers_ff;
      skip_nx    = skip_ff;
      rtype_nx   = rtype_ff;
      rdlen_nx   = rdlen_ff;
      addr_nx    = addr_ff;
      outcome_nx = outcome_ff;
      if (outcome_ff == StNone) begin
         unique case (phase_ff)
            PH_HDR: begin
               if (pos_ff == AnCountHiPos) begin
                  answers_nx = {b, 8'h00};
               end else if (pos_ff == AnCountLoPos) begin
                  answers_nx = {answers_ff[15:8], b};
               end
               if (pos_ff == HdrLastPos) begin
                  if (answers_ff == 16'd0) begin
                     outcome_nx = StNoAns;
                     phase_nx   = PH_DONE;
                  end else begin
                     phase_nx = PH_QNAME;
                  end
               end
               pos_nx = pos_ff + 4'd1;
            end
            PH_QNAME: begin
               if (is_ptr) begin
                  skip_nx  = QTailPtrLen;
                  phase_nx = PH_QTAIL;
               end else if (b == 8'd0) begin
                  skip_nx  = QTailLen;
                  phase_nx = PH_QTAIL;
               end else begin
                  skip_nx  = {8'd0, b};
                  phase_nx = PH_QLABEL;
               end
            end
            PH_ANAME: begin
               if (is_ptr) begin
                  skip_nx  = PtrTailLen;
                  phase_nx = PH_ASKIP;
               end else if (b == 8'd0) begin
                  pos_nx   = 4'd0;
                  phase_nx = PH_FIXED;
               end else begin
                  skip_nx  = {8'd0, b};
                  phase_nx = PH_ALABEL;
               end
            end
            PH_QLABEL: begin
               skip_nx = skip_dec;
               if (skip_dec == 16'd0) begin
                  phase_nx = PH_QNAME;
               end
            end
            PH_ALABEL: begin
               skip_nx = skip_dec;
               if (skip_dec == 16'd0) begin
                  phase_nx = PH_ANAME;
               end
            end
            PH_QTAIL, PH_RSKIP: begin
               skip_nx = skip_dec;
               if (skip_dec == 16'd0) begin
                  phase_nx = PH_ANAME;
               end
            end
            PH_ASKIP: begin
               skip_nx = skip_dec;
               if (skip_dec == 16'd0) begin
                  pos_nx   = 4'd0;
                  phase_nx = PH_FIXED;
               end
            end
            PH_FIXED: begin
               if (pos_ff == TypeHiPos) begin
                  rtype_nx = {b, 8'h00};
               end else if (pos_ff == TypeLoPos) begin
                  rtype_nx = {rtype_ff[15:8], b};
               end else if (pos_ff == RdLenHiPos) begin
                  rdlen_nx = {b, 8'h00};
               end else if (pos_ff == RdLenLoPos) begin
                  rdlen_nx = {rdlen_ff[15:8], b};
               end
               pos_nx = pos_ff + 4'd1;
               // Fixed part complete: decide what follows the record.
               if (pos_ff == RdLenLoPos) begin
                  answers_nx = answers_dec;
                  if (rtype_nx == TypeA && rdlen_nx == ALen) begin
                     pos_nx   = 4'd0;
                     addr_nx  = 32'd0;
                     phase_nx = PH_RDATA;
                  end else if (answers_dec == 16'd0) begin
                     outcome_nx = StNoA;
                     phase_nx   = PH_DONE;
                  end else if (rdlen_nx == 16'd0) begin
                     phase_nx = PH_ANAME;
                  end else begin
                     skip_nx  = rdlen_nx;
                     phase_nx = PH_RSKIP;
                  end
               end
            end
            PH_RDATA: begin
               addr_nx = {addr_ff[23:0], b};
               pos_nx  = pos_ff + 4'd1;
               if (pos_ff == AddrLastPos) begin
                  outcome_nx = StFound;
                  phase_nx   = PH_DONE;
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Status of the message as it stands after this byte.
   always_comb begin
      if (outcome_nx != StNone) begin
         status = outcome_nx;
      end else if (phase_nx == PH_HDR) begin
         status = StShort;
      end else begin
         status = StTrunc;
      end
   end

   assign result.valid        = step && item.last;
   assign result.status       = status;
   assign result.ipv4_address = (status == StFound) ? addr_nx : 32'd0;

   // The final byte returns the parser to its reset state.
   always_comb begin
      if (item.last) begin
         phase_in   = PH_HDR;
         pos_in     = 4'd0;
         answers_in = 16'd0;
         skip_in    = 16'd0;
         rtype_in   = 16'd0;
         rdlen_in   = 16'd0;
         addr_in    = 32'd0;
         outcome_in = StNone;
      end else begin
         phase_in   = phase_nx;
         pos_in     = pos_nx;
         answers_in = answers_nx;
         skip_in    = skip_nx;
         rtype_in   = rtype_nx;
         rdlen_in   = rdlen_nx;
         addr_in    = addr_nx;
         outcome_in = outcome_nx;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR;
         pos_ff     <= 4'd0;
         answers_ff <= 16'd0;
         skip_ff    <= 16'd0;
         rtype_ff   <= 16'd0;
         rdlen_ff   <= 16'd0;
         addr_ff    <= 32'd0;
         outcome_ff <= StNone;
      end else if (step) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         answers_ff <= answers_in;
         skip_ff    <= skip_in;
         rtype_ff   <= rtype_in;
         rdlen_ff   <= rdlen_in;
         addr_ff    <= addr_in;
         outcome_ff <= outcome_in;
      end
   end

   // A fixed outcome always goes with the finished phase.
   a_outcome_done: assert property (@(posedge clock) disable iff (reset)
      (outcome_ff != StNone) |-> (phase_ff == PH_DONE))
      else $error("outcome fixed outside the finished phase");

   // A completed message leaves the parser in its reset state.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (step && item.last) |=> (phase_ff == PH_HDR && outcome_ff == StNone))
      else $error("parser did not restart after the final byte");

endmodule
